### src/srpt_pkg.sv
`default_nettype none
package srpt_pkg;

  localparam int unsigned DefTableDepth = 256;
  localparam int unsigned CapWidth = 9;
  localparam logic [CapWidth-1:0] CapReset = 9'd256;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [31:0] handle;
    logic [30:0] start;
    logic [30:0] count;
  } entry_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [8:0]  entry_index;
    logic [31:0] found_handle;
    logic [31:0] left_bound;
    logic        left_valid;
    logic [30:0] right_bound;
    logic        right_valid;
    logic [8:0]  entries_now;
  } result_t;

endpackage
`default_nettype wire

### src/srpt_in_if.sv
`default_nettype none
interface srpt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [30:0] record_number;
  logic [31:0] page_handle;
  logic [30:0] record_count;
  modport source (output valid, mode, record_number, page_handle, record_count, input ready);
  modport sink (input valid, mode, record_number, page_handle, record_count, output ready);
endinterface
`default_nettype wire

### src/srpt_out_if.sv
`default_nettype none
interface srpt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [8:0]  entry_index;
  logic [31:0] found_handle;
  logic [31:0] left_bound;
  logic        left_valid;
  logic [30:0] right_bound;
  logic        right_valid;
  logic [8:0]  entries_now;
  modport source (output valid, status, entry_index, found_handle, left_bound, left_valid,
                  right_bound, right_valid, entries_now, input ready);
  modport sink (input valid, status, entry_index, found_handle, left_bound, left_valid,
                right_bound, right_valid, entries_now, output ready);
endinterface
`default_nettype wire

### src/srpt_cfg_if.sv
`default_nettype none
interface srpt_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

### src/sorted_range_page_table_top.sv
// sequence: an accepted item is first compared in all cells, then the block goes on to
// select and shift; a result held by out_o.ready keeps the block in select until taken
// input ready only while idle, so a new item is taken only after the last result is registered;
// each cell compares its start and the table shifts by one slot in parallel on insert or remove
// reset: entry count cleared to zero, capacity set to 256, table contents undefined until written
`default_nettype none
module sorted_range_page_table_top #(
  parameter int unsigned TableDepth = srpt_pkg::DefTableDepth
) (
  input wire clk_i,
  input wire rst_ni,
  srpt_in_if.sink    in_i,
  srpt_out_if.source out_o,
  srpt_cfg_if.sink   cfg_i
);
  import srpt_pkg::*;

  localparam int unsigned IdxWidth = $clog2(TableDepth + 1);
  localparam int unsigned LimWidth = (IdxWidth > CapWidth) ? IdxWidth : CapWidth;
  localparam logic [LimWidth-1:0] DepthL = LimWidth'(TableDepth);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_SEL  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [IdxWidth-1:0] total_q, total_d;
  logic [CapWidth-1:0] cap_q;
  logic [1:0]          mode_q;
  logic [30:0]         rec_q;
  entry_t              new_q;
  result_t             res_q, res_d;
  logic                out_valid_q, out_valid_d;

  entry_t ent [TableDepth];
  logic   le  [TableDepth];
  logic   ins_en, rem_en, go;
  logic [IdxWidth-1:0] pos, shift_pos;

  // selection
  entry_t prev_e, next_e;
  logic   has_prev, hit, has_next;
  logic [LimWidth-1:0] limit;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign go = !out_valid_q || out_o.ready;

  always_comb begin
    prev_e = '0;
    next_e = '0;
    pos    = '0;
    for (int i = 0; i < TableDepth; i++) begin
      if (le[i] && ((i == TableDepth - 1) || !le[(i + 1) % TableDepth])) begin
        prev_e = prev_e | ent[i];
        pos    = pos | IdxWidth'(i + 1);
      end
      if (!le[i] && ((i == 0) || le[(i + TableDepth - 1) % TableDepth])) begin
        next_e = next_e | ent[i];
      end
    end
    has_prev = (pos != '0);
    has_next = (pos < total_q);
    hit = has_prev && ({1'b0, rec_q} < ({1'b0, prev_e.start} + {1'b0, prev_e.count}));
    limit = (LimWidth'(cap_q) < DepthL) ? LimWidth'(cap_q) : DepthL;
  end

  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    ins_en      = 1'b0;
    rem_en      = 1'b0;
    shift_pos   = pos;
    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;
    unique case (state_q)
      S_IDLE: if (in_i.valid) state_d = S_CMP;
      S_CMP:  state_d = S_SEL;
      S_SEL: begin
        if (go) begin
          state_d = S_IDLE;
          out_valid_d = 1'b1;
          res_d = '0;
          case (mode_q)
            MODE_LOOKUP: begin
              if (hit) begin
                res_d.entry_index  = 9'(pos - 1'b1);
                res_d.found_handle = prev_e.handle;
              end else begin
                res_d.status      = ST_MISS;
                res_d.entry_index = 9'(pos);
                res_d.left_valid  = has_prev;
                res_d.left_bound  = has_prev ?
                  ({1'b0, prev_e.start} + {1'b0, prev_e.count} - 32'd1) : '0;
                res_d.right_valid = has_next;
                res_d.right_bound = has_next ? next_e.start : '0;
              end
            end
            MODE_INSERT: begin
              if (hit) begin
                res_d.status       = ST_MISS;
                res_d.entry_index  = 9'(pos - 1'b1);
                res_d.found_handle = prev_e.handle;
              end else if (LimWidth'(total_q) >= limit) begin
                res_d.status      = ST_FULL;
                res_d.entry_index = 9'(pos);
              end else begin
                ins_en = 1'b1;
                total_d = total_q + 1'b1;
                res_d.entry_index  = 9'(pos);
                res_d.found_handle = new_q.handle;
              end
            end
            MODE_REMOVE: begin
              if (hit) begin
                rem_en    = 1'b1;
                shift_pos = pos - 1'b1;
                total_d   = total_q - 1'b1;
                res_d.entry_index  = 9'(pos - 1'b1);
                res_d.found_handle = prev_e.handle;
              end else begin
                res_d.status      = ST_MISS;
                res_d.entry_index = 9'(pos);
              end
            end
            default: total_d = '0;
          endcase
          res_d.entries_now = 9'(total_d);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= '0;
      cap_q       <= CapReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) cap_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (in_i.valid && in_i.ready) begin
      mode_q       <= in_i.mode;
      rec_q        <= in_i.record_number;
      new_q.handle <= in_i.page_handle;
      new_q.start  <= in_i.record_number;
      new_q.count  <= in_i.record_count;
    end
  end

  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    srpt_cell #(.IdxWidth(IdxWidth), .Index(g)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmp_en_i (state_q == S_CMP),
      .ins_en_i (ins_en),
      .rem_en_i (rem_en),
      .pos_i    (shift_pos),
      .total_i  (total_q),
      .rec_i    (rec_q),
      .new_i    (new_q),
      .left_i   (ent[(g + TableDepth - 1) % TableDepth]),
      .right_i  (ent[(g + 1) % TableDepth]),
      .entry_o  (ent[g]),
      .le_o     (le[g])
    );
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = res_q.status;
  assign out_o.entry_index  = res_q.entry_index;
  assign out_o.found_handle = res_q.found_handle;
  assign out_o.left_bound   = res_q.left_bound;
  assign out_o.left_valid   = res_q.left_valid;
  assign out_o.right_bound  = res_q.right_bound;
  assign out_o.right_valid  = res_q.right_valid;
  assign out_o.entries_now  = res_q.entries_now;
endmodule
`default_nettype wire

### src/srpt_cell.sv
`default_nettype none
module srpt_cell #(
  parameter int unsigned IdxWidth = 9,
  parameter int unsigned Index = 0
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cmp_en_i,
  input  wire                   ins_en_i,
  input  wire                   rem_en_i,
  input  wire [IdxWidth-1:0]    pos_i,
  input  wire [IdxWidth-1:0]    total_i,
  input  wire [30:0]            rec_i,
  input  srpt_pkg::entry_t      new_i,
  input  srpt_pkg::entry_t      left_i,
  input  srpt_pkg::entry_t      right_i,
  output srpt_pkg::entry_t      entry_o,
  output logic                  le_o
);
  import srpt_pkg::*;

  localparam logic [IdxWidth-1:0] MyIdx = IdxWidth'(Index);

  entry_t entry_q, entry_d;
  logic   le_q;

  always_comb begin
    entry_d = entry_q;
    if (ins_en_i) begin
      if (MyIdx > pos_i) entry_d = left_i;
      else if (MyIdx == pos_i) entry_d = new_i;
    end else if (rem_en_i) begin
      if (MyIdx >= pos_i) entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      le_q <= 1'b0;
    end else if (cmp_en_i) begin
      le_q <= (MyIdx < total_i) && (entry_q.start <= rec_i);
    end
  end

  assign entry_o = entry_q;
  assign le_o    = le_q;
endmodule
`default_nettype wire

### tb/tb_sorted_range_page_table_top.sv
`default_nettype none
module tb_sorted_range_page_table_top;
  import srpt_pkg::*;

  typedef struct packed {
    logic [1:0]  mode;
    logic [30:0] rec;
    logic [31:0] handle;
    logic [30:0] count;
  } page_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  srpt_in_if  in_ch();
  srpt_out_if out_ch();
  srpt_cfg_if cfg_ch();

  sorted_range_page_table_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch), .cfg_i(cfg_ch)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0] tbl_handle [0:255];
  logic [30:0] tbl_start  [0:255];
  logic [30:0] tbl_count  [0:255];
  int unsigned tbl_total;
  int unsigned cap_now;

  page_req_t pending_reqs[$];
  result_t   expected_results[$];

  int unsigned send_idle_pct = 14;
  int unsigned recv_idle_pct = 46;
  int unsigned hold_cycles = 0;
  int unsigned mismatches = 0;
  bit          timed_out = 1'b0;

  // index of last entry with start <= rec, plus one
  function automatic int unsigned upper_slot(logic [30:0] rec);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = tbl_total;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (rec < tbl_start[mid]) hi = mid;
      else lo = mid + 1;
    end
    return lo;
  endfunction

  function automatic bit hit_slot(logic [30:0] rec, output int unsigned idx);
    int unsigned pos;
    logic [31:0] last_end;
    pos = upper_slot(rec);
    if (pos > 0) begin
      last_end = {1'b0, tbl_start[pos-1]} + {1'b0, tbl_count[pos-1]};
      if ({1'b0, rec} < last_end) begin
        idx = pos - 1;
        return 1'b1;
      end
    end
    idx = pos;
    return 1'b0;
  endfunction

  function automatic result_t apply_page_req(page_req_t r);
    result_t res;
    int unsigned idx, lim, i;
    bit hit;
    res = '0;
    res.status = ST_DONE;
    case (mode_e'(r.mode))
      MODE_LOOKUP: begin
        hit = hit_slot(r.rec, idx);
        if (hit) begin
          res.found_handle = tbl_handle[idx];
        end else begin
          res.status = ST_MISS;
          if (idx > 0) begin
            res.left_bound = {1'b0, tbl_start[idx-1]} + {1'b0, tbl_count[idx-1]} - 32'd1;
            res.left_valid = 1'b1;
          end
          if (idx < tbl_total) begin
            res.right_bound = tbl_start[idx];
            res.right_valid = 1'b1;
          end
        end
      end
      MODE_INSERT: begin
        lim = (cap_now < 256) ? cap_now : 256;
        hit = hit_slot(r.rec, idx);
        if (hit) begin
          res.status = ST_MISS;
          res.found_handle = tbl_handle[idx];
        end else if (tbl_total >= lim) begin
          res.status = ST_FULL;
        end else begin
          for (i = tbl_total; i > idx; i--) begin
            tbl_handle[i] = tbl_handle[i-1];
            tbl_start[i] = tbl_start[i-1];
            tbl_count[i] = tbl_count[i-1];
          end
          tbl_handle[idx] = r.handle;
          tbl_start[idx] = r.rec;
          tbl_count[idx] = r.count;
          tbl_total++;
          res.found_handle = r.handle;
        end
      end
      MODE_REMOVE: begin
        hit = hit_slot(r.rec, idx);
        if (hit) begin
          res.found_handle = tbl_handle[idx];
          for (i = idx; i + 1 < tbl_total; i++) begin
            tbl_handle[i] = tbl_handle[i+1];
            tbl_start[i] = tbl_start[i+1];
            tbl_count[i] = tbl_count[i+1];
          end
          tbl_total--;
        end else begin
          res.status = ST_MISS;
        end
      end
      default: begin
        idx = 0;
        tbl_total = 0;
      end
    endcase
    res.entry_index = idx[8:0];
    res.entries_now = tbl_total[8:0];
    return res;
  endfunction

  function automatic page_req_t mk_req(logic [1:0] m, logic [30:0] rec, logic [31:0] h,
                                       logic [30:0] c);
    page_req_t r;
    r.mode = m;
    r.rec = rec;
    r.handle = h;
    r.count = c;
    return r;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.mode <= '0;
      in_ch.record_number <= '0;
      in_ch.page_handle <= '0;
      in_ch.record_count <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) void'(pending_reqs.pop_front());
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.mode <= pending_reqs[0].mode;
        in_ch.record_number <= pending_reqs[0].rec;
        in_ch.page_handle <= pending_reqs[0].handle;
        in_ch.record_count <= pending_reqs[0].count;
        expected_results.push_back(apply_page_req(pending_reqs[0]));
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.status = out_ch.status;
        got.entry_index = out_ch.entry_index;
        got.found_handle = out_ch.found_handle;
        got.left_bound = out_ch.left_bound;
        got.left_valid = out_ch.left_valid;
        got.right_bound = out_ch.right_bound;
        got.right_valid = out_ch.right_valid;
        got.entries_now = out_ch.entries_now;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: exp st=%0d idx=%0d fh=%h lb=%h lv=%b rb=%h rv=%b n=%0d",
                       want.status, want.entry_index, want.found_handle, want.left_bound,
                       want.left_valid, want.right_bound, want.right_valid, want.entries_now);
              $display("          got st=%0d idx=%0d fh=%h lb=%h lv=%b rb=%h rv=%b n=%0d",
                       got.status, got.entry_index, got.found_handle, got.left_bound,
                       got.left_valid, got.right_bound, got.right_valid, got.entries_now);
            end
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic write_capacity(int unsigned cap);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= cap[8:0];
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cap_now = cap;
  endtask

  task automatic drain_results();
    while (pending_reqs.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // random item, aimed near an existing range start half of the time when the table is not empty
  function automatic page_req_t rand_req(int unsigned span);
    page_req_t r;
    int unsigned k, pick;
    k = $urandom_range(99);
    r.handle = $urandom();
    if ($urandom_range(3) == 0) r.count = 31'($urandom());
    else r.count = 31'($urandom_range(span / 4));
    if ($urandom_range(15) == 0) r.count = '0;
    if (tbl_total > 0 && $urandom_range(1)) begin
      pick = $urandom_range(tbl_total - 1);
      r.rec = 31'(tbl_start[pick] + $urandom_range(3) - 1);
    end else if ($urandom_range(7) == 0) begin
      r.rec = 31'($urandom());
    end else begin
      r.rec = 31'($urandom_range(span));
    end
    if (k < 40) r.mode = MODE_INSERT;
    else if (k < 75) r.mode = MODE_LOOKUP;
    else if (k < 98) r.mode = MODE_REMOVE;
    else r.mode = MODE_CLEAR;
    return r;
  endfunction

  // a fresh predictor copy would diverge, so random items are made on the fly
  // from the predicted table state, with at most three items waiting in the queue
  task automatic run_random(int unsigned n, int unsigned span);
    for (int unsigned i = 0; i < n; i++) begin
      while (pending_reqs.size() > 2) @(posedge clk_i);
      pending_reqs.push_back(rand_req(span));
    end
  endtask

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    cap_now = 256;
    tbl_total = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: empty table, extremes, duplicate, zero count, wraps, clear
    pending_reqs.push_back(mk_req(MODE_LOOKUP, 31'd0, 32'd0, 31'd0));
    pending_reqs.push_back(mk_req(MODE_REMOVE, 31'd5, 32'd0, 31'd0));
    pending_reqs.push_back(mk_req(MODE_INSERT, 31'd100, 32'hffffffff, 31'd10));
    pending_reqs.push_back(mk_req(MODE_INSERT, 31'd105, 32'h1234, 31'd3));
    pending_reqs.push_back(mk_req(MODE_INSERT, 31'd0, 32'h0, 31'd0));
    pending_reqs.push_back(mk_req(MODE_INSERT, 31'd0, 32'h55, 31'd0));
    pending_reqs.push_back(mk_req(MODE_INSERT, 31'h7fffffff, 32'haaaa5555, 31'h7fffffff));
    pending_reqs.push_back(mk_req(MODE_INSERT, 31'h7ffffff0, 32'h5555aaaa, 31'h7fffffff));
    pending_reqs.push_back(mk_req(MODE_LOOKUP, 31'd0, 32'd0, 31'd0));
    pending_reqs.push_back(mk_req(MODE_LOOKUP, 31'd109, 32'd0, 31'd0));
    pending_reqs.push_back(mk_req(MODE_LOOKUP, 31'd110, 32'hffffffff, 31'h7fffffff));
    pending_reqs.push_back(mk_req(MODE_LOOKUP, 31'd99, 32'd0, 31'd0));
    pending_reqs.push_back(mk_req(MODE_LOOKUP, 31'h7fffffff, 32'd0, 31'd0));
    pending_reqs.push_back(mk_req(MODE_REMOVE, 31'd104, 32'd0, 31'd0));
    pending_reqs.push_back(mk_req(MODE_REMOVE, 31'd0, 32'd0, 31'd0));
    pending_reqs.push_back(mk_req(MODE_LOOKUP, 31'd50, 32'd0, 31'd0));
    pending_reqs.push_back(mk_req(MODE_CLEAR, 31'h7fffffff, 32'hffffffff, 31'h7fffffff));
    pending_reqs.push_back(mk_req(MODE_LOOKUP, 31'd100, 32'd0, 31'd0));
    drain_results();

    // capacity of one: second insert is full
    write_capacity(1);
    pending_reqs.push_back(mk_req(MODE_INSERT, 31'd10, 32'd1, 31'd5));
    pending_reqs.push_back(mk_req(MODE_INSERT, 31'd20, 32'd2, 31'd5));
    pending_reqs.push_back(mk_req(MODE_INSERT, 31'd12, 32'd3, 31'd5));
    drain_results();

    write_capacity(0);
    pending_reqs.push_back(mk_req(MODE_INSERT, 31'd30, 32'd4, 31'd5));
    pending_reqs.push_back(mk_req(MODE_CLEAR, 31'd0, 32'd0, 31'd0));
    pending_reqs.push_back(mk_req(MODE_INSERT, 31'd30, 32'd4, 31'd5));
    drain_results();

    write_capacity(8);
    run_random(500, 400);
    drain_results();

    // long receiver stall while the sender keeps offering
    hold_cycles = 300;
    run_random(40, 400);
    drain_results();

    send_idle_pct = 46;
    recv_idle_pct = 14;
    write_capacity(256);
    run_random(700, 100000);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_capacity(511);
    run_random(400, 2000);
    drain_results();
    write_capacity(37);
    run_random(360, 300);
    drain_results();

    if (mismatches == 0 && !timed_out) begin
      $display("sorted_range_page_table_top regression: pass");
    end else begin
      $display("sorted_range_page_table_top regression: fail");
    end
    $finish;
  end

  initial begin
    #4000000;
    timed_out = 1'b1;
    $display("sorted_range_page_table_top regression: fail");
    $finish;
  end

endmodule
`default_nettype wire

### sorted_range_page_table_top.f
src/srpt_pkg.sv
src/srpt_in_if.sv
src/srpt_out_if.sv
src/srpt_cfg_if.sv
src/srpt_cell.sv
src/sorted_range_page_table_top.sv
tb/tb_sorted_range_page_table_top.sv
